// ===== rtl/eipm_pkg.sv =====
package eipm_pkg;

  localparam int unsigned LineW  = 16;
  localparam int unsigned ColW   = 12;
  localparam int unsigned ShiftW = 13;
  localparam int unsigned MapW   = 14;
  localparam int unsigned EntryW = LineW + ColW + ColW + ShiftW;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_MAP   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_DUP  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic finish;
  } eipm_cmd_t;

  typedef struct packed {
    logic scan_go;
    logic last_idx;
  } eipm_stat_t;

endpackage

// ===== rtl/eipm_ram.sv =====
module eipm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/eipm_ctrl.sv =====
module eipm_ctrl
  import eipm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  eipm_stat_t stat_i,
  output eipm_cmd_t  cmd_o,
  output logic       busy_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_LAST   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.rd_en  = 1'b0;
    cmd_o.finish = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.scan_go ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (stat_i.last_idx) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/eipm_dpath.sv =====
module eipm_dpath
  import eipm_pkg::*;
#(
  parameter int unsigned Entries = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  eipm_cmd_t                cmd_i,
  output eipm_stat_t               stat_o,
  input  logic [1:0]               req_type_i,
  input  logic [LineW-1:0]         line_number_i,
  input  logic [ColW-1:0]          start_col_i,
  input  logic [ColW-1:0]          end_col_i,
  input  logic signed [ShiftW-1:0] shift_i,
  input  logic [ColW-1:0]          column_i,
  output logic signed [MapW-1:0]   mapped_col_o,
  output logic                     inside_expansion_o,
  output logic [1:0]               status_o,
  output logic                     done_o
);

  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);

  logic [1:0]        req_q;
  logic [LineW-1:0]  line_q;
  logic [ColW-1:0]   start_q;
  logic [ColW-1:0]   end_q;
  logic [ShiftW-1:0] shift_q;
  logic [ColW-1:0]   col_q;

  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;
  logic            rd_vld_q;

  logic              dup_q;
  logic              found_q;
  logic              best_vld_q;
  logic [ColW-1:0]   best_start_q;
  logic [ShiftW-1:0] best_shift_q;

  logic signed [MapW-1:0] mapped_q;
  logic                   inside_q;
  logic [1:0]             status_q;
  logic                   done_q;

  logic [EntryW-1:0] rdata;
  logic [LineW-1:0]  e_line;
  logic [ColW-1:0]   e_start;
  logic [ColW-1:0]   e_end;
  logic [ShiftW-1:0] e_shift;
  logic              line_hit;
  logic              before_col;
  logic              full;
  logic              do_write;
  logic signed [MapW-1:0] map_sum;

  assign {e_line, e_start, e_end, e_shift} = rdata;
  assign line_hit   = (e_line == line_q);
  assign before_col = (e_start < col_q);
  assign full       = (count_q == CntW'(Entries));
  assign do_write   = cmd_i.finish && (req_q == REQ_ADD) && !dup_q && !full;
  assign map_sum    = $signed({2'b00, col_q}) + $signed({best_shift_q[ShiftW-1], best_shift_q});

  assign stat_o.scan_go  = ((req_type_i == REQ_ADD) || (req_type_i == REQ_MAP)) &&
                           (count_q != '0);
  assign stat_o.last_idx = ((CntW'(idx_q) + CntW'(1)) == count_q);

  eipm_ram #(
    .Width(EntryW),
    .Depth(Entries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (do_write),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i({line_q, start_q, end_q, shift_q}),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      line_q  <= line_number_i;
      start_q <= start_col_i;
      end_q   <= end_col_i;
      shift_q <= shift_i;
      col_q   <= column_i;
    end
    if (cmd_i.load) begin
      dup_q        <= 1'b0;
      found_q      <= 1'b0;
      best_vld_q   <= 1'b0;
      best_start_q <= '0;
      best_shift_q <= '0;
    end else if (rd_vld_q && line_hit) begin
      if (e_start == start_q) begin
        dup_q <= 1'b1;
      end
      if (before_col) begin
        if (col_q < e_end) begin
          found_q <= 1'b1;
        end
        if (!best_vld_q || (e_start > best_start_q)) begin
          best_vld_q   <= 1'b1;
          best_start_q <= e_start;
          best_shift_q <= e_shift;
        end
      end
    end
    if (cmd_i.finish) begin
      mapped_q <= '0;
      inside_q <= 1'b0;
      status_q <= STATUS_DONE;
      case (req_q)
        REQ_ADD: begin
          if (dup_q) begin
            status_q <= STATUS_DUP;
          end else if (full) begin
            status_q <= STATUS_FULL;
          end
        end
        REQ_MAP: begin
          if (found_q) begin
            inside_q <= 1'b1;
          end else begin
            mapped_q <= map_sum;
          end
        end
        default: begin
          status_q <= STATUS_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      done_q   <= cmd_i.finish;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.rd_en) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.finish && (req_q == REQ_CLEAR)) begin
        count_q <= '0;
      end else if (do_write) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  assign mapped_col_o       = mapped_q;
  assign inside_expansion_o = inside_q;
  assign status_o           = status_q;
  assign done_o             = done_q;

endmodule

// ===== rtl/expansion_interval_position_map_core.sv =====
// Table of up to ENTRIES expansion intervals with add, map and clear requests.
// A request is taken when start is high and busy is low; its one result
// appears on mapped_col_o, inside_expansion_o and status_o for a single cycle
// with done_o high and must be captured then, as the receiver cannot stall it.
// Add and map requests read the stored intervals one per cycle through the
// single read port of the interval table, reading every interval held (at
// most ENTRIES) before the result; clear, unused codes and requests on an
// empty table skip the read pass. Intervals fill the table from slot zero
// and a clear only resets the fill count, so no clearing pass is needed
// after reset.
module expansion_interval_position_map_core
  import eipm_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type_i,
  input  logic [LineW-1:0]         line_number_i,
  input  logic [ColW-1:0]          start_col_i,
  input  logic [ColW-1:0]          end_col_i,
  input  logic signed [ShiftW-1:0] shift_i,
  input  logic [ColW-1:0]          column_i,
  output logic                     done_o,
  output logic signed [MapW-1:0]   mapped_col_o,
  output logic                     inside_expansion_o,
  output logic [1:0]               status_o
);

  eipm_cmd_t  cmd;
  eipm_stat_t stat;

  eipm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  eipm_dpath #(
    .Entries(ENTRIES)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_type_i        (req_type_i),
    .line_number_i     (line_number_i),
    .start_col_i       (start_col_i),
    .end_col_i         (end_col_i),
    .shift_i           (shift_i),
    .column_i          (column_i),
    .mapped_col_o      (mapped_col_o),
    .inside_expansion_o(inside_expansion_o),
    .status_o          (status_o),
    .done_o            (done_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a request in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && inside_expansion_o |-> (status_o == STATUS_DONE) && (mapped_col_o == '0))
    else $error("inside result with non-zero status or column");

endmodule
